// File: rtl/ptpd_pkg.sv
// Shared constants and register codes of the point to plane distance block.
package ptpd_pkg;

    // Width of the distance result and number of quotient cells.
    localparam int DIST_BITS = 17;

    // Configuration port geometry: 64-bit data, registers on 8-byte steps.
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 2;

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_CORNER_A = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_CORNER_B = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_CORNER_C = 2'd2;

endpackage

// File: rtl/ptpd_ifs.sv
// Stream interfaces for query points and distance results.
interface ptpd_point_if #(
    parameter int COORD_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;

    modport source (output valid, output point_x, output point_y, output point_z, input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

interface ptpd_dist_if;
    logic                            valid;
    logic                            ready;
    logic [ptpd_pkg::DIST_BITS-1:0]  distance;
    logic                            degenerate;

    modport source (output valid, output distance, output degenerate, input ready);
    modport sink   (input valid, input distance, input degenerate, output ready);
endinterface

// File: rtl/ptpd_front.sv
// Front pipeline: plane normal, dot product and squared terms ahead of the quotient cells.
module ptpd_front #(
    parameter int COORD_WIDTH = 16,
    localparam int W   = COORD_WIDTH,
    localparam int DW  = 3 * W + 5,
    localparam int SW  = 4 * W + 6,
    localparam int DDW = 2 * DW
) (
    input  logic                   clk,
    input  logic [8:1]             en,
    input  logic [3*W-1:0]         corner_a,
    input  logic [3*W-1:0]         corner_b,
    input  logic [3*W-1:0]         corner_c,
    input  logic signed [W-1:0]    point_x,
    input  logic signed [W-1:0]    point_y,
    input  logic signed [W-1:0]    point_z,
    output logic [DDW-1:0]         dd,
    output logic [SW-1:0]          s_sum,
    output logic                   degenerate
);
    localparam int WD  = W + 1;
    localparam int NW  = 2 * W + 3;
    localparam int NMW = 2 * W + 2;
    localparam int H   = W + 1;
    localparam int TMW = 3 * W + 3;
    localparam int DSW = 3 * W + 6;
    localparam int DH  = (DW + 1) / 2;
    localparam int DL  = DW - DH;

    logic signed [W-1:0]     a [3];
    logic signed [W-1:0]     b [3];
    logic signed [W-1:0]     c [3];
    logic signed [W-1:0]     p [3];
    logic signed [WD-1:0]    u [3];
    logic signed [WD-1:0]    v [3];
    logic signed [2*WD-1:0]  pa [3];
    logic signed [2*WD-1:0]  pb [3];

    // Normal side, driven only by the corner registers.
    logic signed [NW-1:0]    n_reg [3];
    logic [NMW-1:0]          nmag_reg [3];
    logic                    nneg_reg [3];
    logic                    deg_reg;
    logic [2*H-1:0]          sql_reg [3];
    logic [2*H-1:0]          sqm_reg [3];
    logic [2*H-1:0]          sqh_reg [3];
    logic [2*NMW-1:0]        sq_reg [3];
    logic [SW-1:0]           s_reg;

    // Point side, moving with the stream.
    logic signed [WD-1:0]    d [3];
    logic [WD-1:0]           dmag1_reg [3];
    logic                    dneg1_reg [3];
    logic [WD-1:0]           dmag2_reg [3];
    logic                    dneg2_reg [3];
    logic [WD+H-1:0]         dl_reg [3];
    logic [WD+H-1:0]         dh_reg [3];
    logic                    neg3_reg [3];
    logic [TMW-1:0]          term_reg [3];
    logic                    neg4_reg [3];
    logic signed [DSW-1:0]   tval [3];
    logic signed [DSW-1:0]   dsum_reg;
    logic [DW-1:0]           dabs_reg;
    logic [2*DH-1:0]         ll_reg;
    logic [DH+DL-1:0]        lh_reg;
    logic [2*DL-1:0]         hh_reg;
    logic [DDW-1:0]          dd_reg;

    assign p[0] = point_x;
    assign p[1] = point_y;
    assign p[2] = point_z;

    for (genvar i = 0; i < 3; i++) begin : g_comp
        // Corner coordinates and the edge vectors A-B and A-C.
        assign a[i] = corner_a[(3-i)*W-1 -: W];
        assign b[i] = corner_b[(3-i)*W-1 -: W];
        assign c[i] = corner_c[(3-i)*W-1 -: W];
        assign u[i] = WD'(a[i]) - WD'(b[i]);
        assign v[i] = WD'(a[i]) - WD'(c[i]);
        assign pa[i] = u[(i+1)%3] * v[(i+2)%3];
        assign pb[i] = u[(i+2)%3] * v[(i+1)%3];
        assign d[i] = WD'(p[i]) - WD'(a[i]);
        assign tval[i] = neg4_reg[i] ? -$signed({3'b000, term_reg[i]})
                                     :  $signed({3'b000, term_reg[i]});

        // Cross product, its magnitude and the partial squares.
        always_ff @(posedge clk)
        begin
            n_reg[i]    <= NW'(pa[i]) - NW'(pb[i]);
            nneg_reg[i] <= n_reg[i][NW-1];
            nmag_reg[i] <= n_reg[i][NW-1] ? NMW'(-n_reg[i]) : NMW'(n_reg[i]);
            sql_reg[i]  <= nmag_reg[i][H-1:0] * nmag_reg[i][H-1:0];
            sqm_reg[i]  <= nmag_reg[i][H-1:0] * nmag_reg[i][NMW-1:H];
            sqh_reg[i]  <= nmag_reg[i][NMW-1:H] * nmag_reg[i][NMW-1:H];
            sq_reg[i]   <= (2*NMW)'(sql_reg[i]) + ((2*NMW)'(sqm_reg[i]) << (H + 1))
                         + ((2*NMW)'(sqh_reg[i]) << (2 * H));
        end

        // Offset of the point from corner A, then its products with the normal.
        always_ff @(posedge clk)
        begin
            if (en[1])
            begin
                dneg1_reg[i] <= d[i][WD-1];
                dmag1_reg[i] <= d[i][WD-1] ? WD'(-d[i]) : WD'(d[i]);
            end
            if (en[2])
            begin
                dneg2_reg[i] <= dneg1_reg[i];
                dmag2_reg[i] <= dmag1_reg[i];
            end
            if (en[3])
            begin
                dl_reg[i]   <= dmag2_reg[i] * nmag_reg[i][H-1:0];
                dh_reg[i]   <= dmag2_reg[i] * nmag_reg[i][NMW-1:H];
                neg3_reg[i] <= dneg2_reg[i] ^ nneg_reg[i];
            end
            if (en[4])
            begin
                term_reg[i] <= TMW'(dl_reg[i]) + (TMW'(dh_reg[i]) << H);
                neg4_reg[i] <= neg3_reg[i];
            end
        end
    end

    // Squared normal length and the collinear flag.
    always_ff @(posedge clk)
    begin
        deg_reg <= (n_reg[0] == '0) && (n_reg[1] == '0) && (n_reg[2] == '0);
        s_reg   <= SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);
    end

    // Dot product, its magnitude and its square in partial products.
    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            dsum_reg <= tval[0] + tval[1] + tval[2];
        end
        if (en[6])
        begin
            dabs_reg <= dsum_reg[DSW-1] ? DW'(-dsum_reg) : DW'(dsum_reg);
        end
        if (en[7])
        begin
            ll_reg <= dabs_reg[DH-1:0] * dabs_reg[DH-1:0];
            lh_reg <= dabs_reg[DH-1:0] * dabs_reg[DW-1:DH];
            hh_reg <= dabs_reg[DW-1:DH] * dabs_reg[DW-1:DH];
        end
        if (en[8])
        begin
            dd_reg <= DDW'(ll_reg) + (DDW'(lh_reg) << (DH + 1)) + (DDW'(hh_reg) << (2 * DH));
        end
    end

    assign dd         = dd_reg;
    assign s_sum      = s_reg;
    assign degenerate = deg_reg;

endmodule

// File: rtl/ptpd_cell.sv
// One quotient cell: decides a single distance bit by comparing q*q*S against D*D.
module ptpd_cell #(
    parameter int BIT     = 0,
    parameter int S_WIDTH = 70,
    parameter int D_WIDTH = 106
) (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic [S_WIDTH-1:0]                   s_sum,
    input  logic [ptpd_pkg::DIST_BITS-1:0]          q_in,
    input  logic [ptpd_pkg::DIST_BITS+S_WIDTH-1:0]  qs_in,
    input  logic [D_WIDTH-1:0]                   q2s_in,
    input  logic [D_WIDTH-1:0]                   dd_in,
    output logic [ptpd_pkg::DIST_BITS-1:0]          q_out,
    output logic [ptpd_pkg::DIST_BITS+S_WIDTH-1:0]  qs_out,
    output logic [D_WIDTH-1:0]                   q2s_out,
    output logic [D_WIDTH-1:0]                   dd_out
);
    import ptpd_pkg::*;

    localparam int QSW = DIST_BITS + S_WIDTH;
    localparam int TW  = ((D_WIDTH > 2 * DIST_BITS + S_WIDTH) ? D_WIDTH
                                                              : 2 * DIST_BITS + S_WIDTH) + 2;
    localparam logic [DIST_BITS-1:0] BIT_MASK = DIST_BITS'(1) << BIT;

    logic [TW-1:0]        trial;
    logic                 take;
    logic [DIST_BITS-1:0] q_reg;
    logic [QSW-1:0]       qs_reg;
    logic [D_WIDTH-1:0]   q2s_reg;
    logic [D_WIDTH-1:0]   dd_reg;

    // (q + 2^b)^2 S = q^2 S + 2^(b+1) q S + 2^(2b) S
    assign trial = TW'(q2s_in) + (TW'(qs_in) << (BIT + 1)) + (TW'(s_sum) << (2 * BIT));
    assign take  = trial <= TW'(dd_in);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg   <= take ? (q_in | BIT_MASK) : q_in;
            qs_reg  <= take ? (qs_in + (QSW'(s_sum) << BIT)) : qs_in;
            q2s_reg <= take ? D_WIDTH'(trial) : q2s_in;
            dd_reg  <= dd_in;
        end
    end

    assign q_out   = q_reg;
    assign qs_out  = qs_reg;
    assign q2s_out = q2s_reg;
    assign dd_out  = dd_reg;

endmodule

// File: rtl/point_to_plane_distance_top.sv
// Top level of the point to plane distance block: register port, stream control and cell chain.
//
// Each query point word yields one distance word floor(|(P-A).n| / |n|), n = (A-B) x (A-C),
// saturated to 17 bits; collinear corners give distance 0 with degenerate set. One point is
// taken in every cycle unless back-pressure fills the stages, and each word passes eight front stages
// (point offset, dot product and its square) and then a chain of 17 quotient cells, one cell per
// distance bit from the top bit down, each doing one wide add and compare. Every stage holds
// its word until the next stage can take it, so bubbles close up and new points enter while
// a finished distance waits at the output. The normal is derived from the corner registers
// through its own free-running stages, so a point may follow a register write immediately.
module point_to_plane_distance_top #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    ptpd_point_if.sink                         point_in,
    ptpd_dist_if.source                        dist_out,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ptpd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ptpd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ptpd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import ptpd_pkg::*;

    localparam int W     = COORD_WIDTH;
    localparam int DW    = 3 * W + 5;
    localparam int SW    = 4 * W + 6;
    localparam int DDW   = 2 * DW;
    localparam int QSW   = DIST_BITS + SW;
    localparam int FRONT = 8;
    localparam int L     = FRONT + DIST_BITS;

    logic [3*W-1:0]         corner_a_reg;
    logic [3*W-1:0]         corner_b_reg;
    logic [3*W-1:0]         corner_c_reg;
    logic [REG_IDX_W-1:0]   reg_idx;
    logic                   cfg_wr;

    logic [L:1]             vld_reg;
    logic [L:1]             vld_prev;
    logic [L+1:1]           load;

    logic [DDW-1:0]         dd;
    logic [SW-1:0]          s_sum;
    logic                   deg;

    logic [DIST_BITS-1:0]   q_ch   [DIST_BITS+1];
    logic [QSW-1:0]         qs_ch  [DIST_BITS+1];
    logic [DDW-1:0]         q2s_ch [DIST_BITS+1];
    logic [DDW-1:0]         dd_ch  [DIST_BITS+1];

    // Register port: writes on the access phase, reads return the stored corner or zero.
    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1 -: REG_IDX_W];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_a_reg <= '0;
            corner_b_reg <= '0;
            corner_c_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_CORNER_A: corner_a_reg <= pwdata[3*W-1:0];
                REG_CORNER_B: corner_b_reg <= pwdata[3*W-1:0];
                REG_CORNER_C: corner_c_reg <= pwdata[3*W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_CORNER_A: prdata = APB_DATA_W'(corner_a_reg);
            REG_CORNER_B: prdata = APB_DATA_W'(corner_b_reg);
            REG_CORNER_C: prdata = APB_DATA_W'(corner_c_reg);
            default:      prdata = '0;
        endcase
    end

    // Stage occupancy: a stage loads when it is empty or its word moves on.
    always_comb
    begin
        load[L+1] = dist_out.ready;
        for (int k = L; k >= 1; k--)
        begin
            load[k] = !vld_reg[k] || load[k+1];
        end
    end

    assign vld_prev = {vld_reg[L-1:1], point_in.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 1; k <= L; k++)
            begin
                if (load[k])
                begin
                    vld_reg[k] <= vld_prev[k];
                end
            end
        end
    end

    assign point_in.ready = load[1];

    // Normal, dot product and squared terms.
    ptpd_front #(
        .COORD_WIDTH (W)
    ) u_front (
        .clk        (clk),
        .en         (load[FRONT:1]),
        .corner_a   (corner_a_reg),
        .corner_b   (corner_b_reg),
        .corner_c   (corner_c_reg),
        .point_x    (point_in.point_x),
        .point_y    (point_in.point_y),
        .point_z    (point_in.point_z),
        .dd         (dd),
        .s_sum      (s_sum),
        .degenerate (deg)
    );

    // Quotient cells, most significant bit first.
    assign q_ch[0]   = '0;
    assign qs_ch[0]  = '0;
    assign q2s_ch[0] = '0;
    assign dd_ch[0]  = dd;

    for (genvar j = 0; j < DIST_BITS; j++) begin : g_cell
        ptpd_cell #(
            .BIT     (DIST_BITS - 1 - j),
            .S_WIDTH (SW),
            .D_WIDTH (DDW)
        ) u_cell (
            .clk     (clk),
            .en      (load[FRONT+1+j]),
            .s_sum   (s_sum),
            .q_in    (q_ch[j]),
            .qs_in   (qs_ch[j]),
            .q2s_in  (q2s_ch[j]),
            .dd_in   (dd_ch[j]),
            .q_out   (q_ch[j+1]),
            .qs_out  (qs_ch[j+1]),
            .q2s_out (q2s_ch[j+1]),
            .dd_out  (dd_ch[j+1])
        );
    end

    // Result word from the last cell.
    assign dist_out.valid      = vld_reg[L];
    assign dist_out.distance   = deg ? '0 : q_ch[DIST_BITS];
    assign dist_out.degenerate = deg;

    // An accepted point always lands in the first stage.
    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        point_in.valid && point_in.ready |=> vld_reg[1])
        else $error("accepted point did not enter the first stage");

    // With the first stage, the output stage and the stage ahead of it empty, the input is never blocked.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[L] && !vld_reg[L-1] && !vld_reg[1] |-> point_in.ready)
        else $error("input stalled with free stages");

    // A write to corner A is visible on the next cycle.
    a_corner_a_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr && reg_idx == REG_CORNER_A |=> corner_a_reg == $past(pwdata[3*W-1:0]))
        else $error("corner A write lost");

endmodule

// File: tb/sv/tb_top.sv
// Testbench of the point to plane distance block: random and directed points against a bit-exact predictor.
`timescale 1ns / 100ps

module tb_top;
    import ptpd_pkg::*;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } point_t;

    typedef struct packed {
        logic [DIST_BITS-1:0] distance;
        logic                 degenerate;
    } dist_word_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    ptpd_point_if #(.COORD_WIDTH(16)) pin ();
    ptpd_dist_if dout ();

    point_to_plane_distance_top #(.COORD_WIDTH(16)) u_dut (
        .clk(clk), .rst_n(rst_n), .point_in(pin.sink), .dist_out(dout.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Pending points, expected distance words and the predictor's copy of the corners.
    point_t     pending_points[$];
    dist_word_t expected_dists[$];
    logic [63:0] corner_copy[3];
    int  fail_count;
    bit  steady;
    int  send_gap;
    int  recv_gap;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Exact distance: largest q with q*q*S <= D*D, over the 17 output bits.
    function automatic dist_word_t plane_distance(point_t p);
        longint a[3], b[3], c[3], d[3], u[3], v[3], n[3];
        longint dot, dmag;
        logic [127:0] s, dd, t, q, cand, trial;
        logic signed [15:0] pc[3];
        dist_word_t w;
        pc[0] = p.x;
        pc[1] = p.y;
        pc[2] = p.z;
        for (int i = 0; i < 3; i++)
        begin
            a[i] = longint'($signed(corner_copy[REG_CORNER_A][(2 - i) * 16 +: 16]));
            b[i] = longint'($signed(corner_copy[REG_CORNER_B][(2 - i) * 16 +: 16]));
            c[i] = longint'($signed(corner_copy[REG_CORNER_C][(2 - i) * 16 +: 16]));
            d[i] = longint'(pc[i]) - a[i];
            u[i] = a[i] - b[i];
            v[i] = a[i] - c[i];
        end
        n[0] = u[1] * v[2] - u[2] * v[1];
        n[1] = u[2] * v[0] - u[0] * v[2];
        n[2] = u[0] * v[1] - u[1] * v[0];
        w.distance = '0;
        w.degenerate = 1'b1;
        if (n[0] == 0 && n[1] == 0 && n[2] == 0)
            return w;
        s = '0;
        dot = 0;
        for (int i = 0; i < 3; i++)
        begin
            t = 128'(n[i] < 0 ? -n[i] : n[i]);
            s = s + t * t;
            dot = dot + d[i] * n[i];
        end
        dmag = dot < 0 ? -dot : dot;
        t = 128'(dmag);
        dd = t * t;
        q = '0;
        for (int bit_i = DIST_BITS - 1; bit_i >= 0; bit_i--)
        begin
            cand = q | (128'd1 << bit_i);
            trial = cand * cand * s;
            if (trial <= dd)
                q = cand;
        end
        w.distance = q[DIST_BITS-1:0];
        w.degenerate = 1'b0;
        return w;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // Driver: presents pending points, predicts each accepted word.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pin.valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (pin.valid && pin.ready)
            begin
                expected_dists.push_back(plane_distance(pending_points.pop_front()));
            end
            if (pin.valid && !pin.ready)
            begin
                // Hold the word until it is taken.
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                pin.valid <= 1'b0;
            end
            else if (pending_points.size() > 0)
            begin
                pin.valid   <= 1'b1;
                pin.point_x <= pending_points[0].x;
                pin.point_y <= pending_points[0].y;
                pin.point_z <= pending_points[0].z;
                send_gap = pick_gap();
            end
            else
            begin
                pin.valid <= 1'b0;
            end
        end
    end

    // Monitor: random back pressure, checks each accepted distance word.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dout.ready <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (dout.valid && dout.ready)
            begin
                if (expected_dists.size() == 0)
                begin
                    report("unexpected word", int'(dout.distance), -1);
                end
                else
                begin
                    dist_word_t want;
                    want = expected_dists.pop_front();
                    if (dout.distance !== want.distance)
                        report("distance", int'(dout.distance), int'(want.distance));
                    if (dout.degenerate !== want.degenerate)
                        report("degenerate", int'(dout.degenerate), int'(want.degenerate));
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                dout.ready <= 1'b0;
            end
            else
            begin
                dout.ready <= 1'b1;
                recv_gap = pick_gap();
            end
        end
    end

    // Register write: setup cycle, then access cycle.
    task automatic write_reg(int idx, logic [63:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx * 8);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx < 3)
            corner_copy[idx] = value;
    endtask

    function automatic logic [15:0] rand_coord(bit narrow);
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return 16'h7fff;
        else if (r < 12)
            return 16'h8000;
        else if (narrow || r < 50)
            return 16'($signed($urandom_range(0, 4095)) - 2048);
        else
            return 16'($urandom());
    endfunction

    function automatic logic [63:0] rand_corner(bit narrow);
        logic [63:0] v;
        v = {16'($urandom()), rand_coord(narrow), rand_coord(narrow), rand_coord(narrow)};
        if ($urandom_range(0, 3) != 0)
            v[63:48] = '0;
        return v;
    endfunction

    task automatic load_corners(logic [63:0] ca, logic [63:0] cb, logic [63:0] cc);
        write_reg(REG_CORNER_A, ca);
        write_reg(REG_CORNER_B, cb);
        write_reg(REG_CORNER_C, cc);
    endtask

    task automatic push_random(int count, bit narrow);
        point_t p;
        for (int k = 0; k < count; k++)
        begin
            p.x = rand_coord(narrow);
            p.y = rand_coord(narrow);
            p.z = rand_coord(narrow);
            pending_points.push_back(p);
        end
    endtask

    // Wait until every word is back, then let the pipeline drain.
    task automatic drain();
        wait (pending_points.size() == 0 && expected_dists.size() == 0);
        repeat (40) @(posedge clk);
    endtask

    initial
    begin
        point_t p;
        logic [63:0] ca;
        fail_count = 0;
        steady = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pin.valid = 1'b0;
        pin.point_x = '0;
        pin.point_y = '0;
        pin.point_z = '0;
        dout.ready = 1'b0;
        for (int i = 0; i < 3; i++)
            corner_copy[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Corners all zero after reset: every point is degenerate.
        push_random(8, 1'b0);
        drain();

        // Axis plane through the origin with directed extreme points.
        load_corners(64'h0, {16'h0, 16'h0100, 16'h0, 16'h0}, {16'h0, 16'h0, 16'h0100, 16'h0});
        for (int k = 0; k < 9; k++)
        begin
            p.x = (k % 3 == 0) ? 16'h7fff : (k % 3 == 1) ? 16'h8000 : 16'h0;
            p.y = (k / 3 == 0) ? 16'h7fff : (k / 3 == 1) ? 16'h8000 : 16'h0;
            p.z = (k[0]) ? 16'h8000 : 16'h7fff;
            pending_points.push_back(p);
        end
        drain();

        // Extreme corners and far points: the largest distances.
        load_corners({16'h0, 16'h7fff, 16'h7fff, 16'h7fff},
                     {16'h0, 16'h8000, 16'h8000, 16'h7fff},
                     {16'h0, 16'h8000, 16'h7fff, 16'h8000});
        for (int k = 0; k < 4; k++)
        begin
            p.x = k[0] ? 16'h8000 : 16'h7fff;
            p.y = k[1] ? 16'h8000 : 16'h7fff;
            p.z = 16'h8000;
            pending_points.push_back(p);
        end
        drain();

        // Collinear corners, stray upper bits and a write beyond the last register.
        ca = {16'hffff, 16'h0100, 16'h0200, 16'h0300};
        load_corners(ca, {16'habcd, 16'h0200, 16'h0400, 16'h0600},
                     {16'h0, 16'h0300, 16'h0600, 16'h0900});
        write_reg(3, 64'hdead_beef_0123_4567);
        push_random(6, 1'b0);
        drain();

        // Random planes; one phase runs without idling.
        for (int ph = 0; ph < 10; ph++)
        begin
            bit narrow;
            narrow = ($urandom_range(0, 2) != 0);
            steady = (ph == 4);
            if ($urandom_range(0, 9) == 0)
            begin
                ca = rand_corner(narrow);
                load_corners(ca, ca, rand_corner(narrow));
            end
            else
            begin
                load_corners(rand_corner(narrow), rand_corner(narrow), rand_corner(narrow));
            end
            push_random(100, narrow);
            drain();
        end

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Run time limit.
    initial
    begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// File: files.f
rtl/ptpd_pkg.sv
rtl/ptpd_ifs.sv
rtl/ptpd_front.sv
rtl/ptpd_cell.sv
rtl/point_to_plane_distance_top.sv
tb/sv/tb_top.sv
